### rtl/core/fsbe_pkg.sv
package fsbe_pkg;

  localparam logic [5:0] MLEN_DOUBLE = 6'd52;
  localparam logic [5:0] MLEN_FLOAT  = 6'd23;
  localparam logic [1:0] SIGN_STORE  = 2'd2;

  localparam logic [2:0] REG_DOUBLE_MODE   = 3'd0;
  localparam logic [2:0] REG_SIGN_MODE     = 3'd1;
  localparam logic [2:0] REG_EXPONENT_BITS = 3'd2;
  localparam logic [2:0] REG_MANTISSA_BITS = 3'd3;
  localparam logic [2:0] REG_MIN_EXPONENT  = 3'd4;
  localparam logic [2:0] REG_FILL_ENABLE   = 3'd5;
  localparam logic [2:0] REG_FILL_PATTERN  = 3'd6;
  localparam logic [2:0] REG_FILL_CODE     = 3'd7;

  typedef struct packed {
    logic        double_mode;
    logic [1:0]  sign_mode;
    logic [3:0]  exponent_bits;
    logic [5:0]  mantissa_bits;
    logic [10:0] min_exponent;
    logic        fill_enable;
    logic [63:0] fill_pattern;
    logic [63:0] fill_code;
  } cfg_t;

  // after field split and mantissa shift
  typedef struct packed {
    logic        valid;
    logic        last;
    logic        is_fill;
    logic        sign;
    logic [10:0] expo;
    logic [51:0] mant_sh;
    logic        rnd;
  } split_t;

  // after rounding and exponent offset
  typedef struct packed {
    logic        valid;
    logic        last;
    logic        is_fill;
    logic        sign;
    logic [12:0] offset;
    logic [51:0] kept;
    logic        carry;
    logic [63:0] mask;
  } round_t;

  // kept mantissa bits, saturated to the format length
  function automatic logic [5:0] kept_bits(cfg_t c);
    logic [5:0] mlen;
    mlen = c.double_mode ? MLEN_DOUBLE : MLEN_FLOAT;
    return (c.mantissa_bits > mlen) ? mlen : c.mantissa_bits;
  endfunction

endpackage

### rtl/core/fsbe_split.sv
module fsbe_split (
  input  logic            clk,
  input  logic            rst,
  input  fsbe_pkg::cfg_t  cfg,
  input  logic            in_valid,
  input  logic [63:0]     value_bits,
  input  logic            last_value,
  output fsbe_pkg::split_t s1
);
  import fsbe_pkg::*;

  logic [5:0]  mlen;
  logic [5:0]  m;
  logic [5:0]  shifts;
  logic [51:0] mant;
  logic [52:0] shifted;
  logic [63:0] vm;
  logic [63:0] pm;
  logic        v_mag_zero;
  logic        p_mag_zero;
  logic        match;

  always_comb begin
    mlen   = cfg.double_mode ? MLEN_DOUBLE : MLEN_FLOAT;
    m      = kept_bits(cfg);
    shifts = mlen - m;
    mant   = cfg.double_mode ? value_bits[51:0] : {29'd0, value_bits[22:0]};
    // bit 0 ends up as the first dropped bit, zero when nothing is dropped
    shifted = {mant, 1'b0} >> shifts;

    vm = cfg.double_mode ? value_bits : {32'd0, value_bits[31:0]};
    pm = cfg.double_mode ? cfg.fill_pattern : {32'd0, cfg.fill_pattern[31:0]};
    v_mag_zero = cfg.double_mode ? (vm[62:0] == 63'd0) : (vm[30:0] == 31'd0);
    p_mag_zero = cfg.double_mode ? (pm[62:0] == 63'd0) : (pm[30:0] == 31'd0);
    // plus and minus zero count as equal
    match = cfg.fill_enable && ((vm == pm) || (v_mag_zero && p_mag_zero));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
    end else begin
      s1.valid <= in_valid;
    end
    s1.last    <= last_value;
    s1.is_fill <= match;
    s1.sign    <= cfg.double_mode ? value_bits[63] : value_bits[31];
    s1.expo    <= cfg.double_mode ? value_bits[62:52] : {3'd0, value_bits[30:23]};
    s1.mant_sh <= shifted[52:1];
    s1.rnd     <= shifted[0];
  end

endmodule

### rtl/core/fsbe_round.sv
module fsbe_round (
  input  logic             clk,
  input  logic             rst,
  input  fsbe_pkg::cfg_t   cfg,
  input  fsbe_pkg::split_t s1,
  output fsbe_pkg::round_t s2
);
  import fsbe_pkg::*;

  logic [5:0]  m;
  logic [52:0] kept;
  logic        carry;
  logic [12:0] offset;
  logic [6:0]  total;
  logic [63:0] mask;

  always_comb begin
    m      = kept_bits(cfg);
    kept   = {1'b0, s1.mant_sh} + {52'd0, s1.rnd};
    carry  = (kept == (53'd1 << m));
    // two's complement offset, sign-extended to 64 bits later
    offset = {2'd0, s1.expo} - {2'd0, cfg.min_exponent} + {12'd0, carry};
    total  = {6'd0, cfg.sign_mode == SIGN_STORE} + {3'd0, cfg.exponent_bits} + {1'b0, m};
    mask   = (total >= 7'd64) ? {64{1'b1}} : ((64'd1 << total[5:0]) - 64'd1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2.valid <= 1'b0;
    end else begin
      s2.valid <= s1.valid;
    end
    s2.last    <= s1.last;
    s2.is_fill <= s1.is_fill;
    s2.sign    <= s1.sign;
    s2.offset  <= offset;
    s2.kept    <= kept[51:0];
    s2.carry   <= carry;
    s2.mask    <= mask;
  end

endmodule

### rtl/core/fsbe_pack.sv
module fsbe_pack (
  input  logic             clk,
  input  logic             rst,
  input  fsbe_pkg::cfg_t   cfg,
  input  fsbe_pkg::round_t s2,
  output logic             done,
  output logic [63:0]      code,
  output logic             is_fill,
  output logic             last_code
);
  import fsbe_pkg::*;

  logic [5:0]  m;
  logic [63:0] hi;
  logic [63:0] res;

  always_comb begin
    m   = kept_bits(cfg);
    hi  = {63'd0, (cfg.sign_mode == SIGN_STORE) & s2.sign} << cfg.exponent_bits;
    res = (hi | {{51{s2.offset[12]}}, s2.offset}) << m;
    if (!s2.carry) begin
      res = res | {12'd0, s2.kept};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s2.valid;
    end
    code      <= s2.is_fill ? cfg.fill_code : (res & s2.mask);
    is_fill   <= s2.is_fill;
    last_code <= s2.last;
  end

endmodule

### rtl/core/float_significant_bits_encoder_core.sv
// an item accepted at one clock edge passes the split, round and pack registers
// and shows its result with done high, accepted at the edge that ends that cycle
// throughput: one item per cycle, set by the three-stage split/round/pack pipe
// the receiver cannot stall, so busy stays low and the pipe always advances
// reset (synchronous) restores the config defaults and clears the valid bits of the pipe
module float_significant_bits_encoder_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] value_bits,
  input  logic        last_value,
  input  logic        wr_en,
  input  logic [2:0]  wr_index,
  input  logic [63:0] wr_data,
  output logic        done,
  output logic [63:0] code,
  output logic        is_fill,
  output logic        last_code
);
  import fsbe_pkg::*;

  cfg_t   cfg;
  split_t s1;
  round_t s2;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.double_mode   <= 1'b1;
      cfg.sign_mode     <= SIGN_STORE;
      cfg.exponent_bits <= 4'd11;
      cfg.mantissa_bits <= MLEN_DOUBLE;
      cfg.min_exponent  <= 11'd0;
      cfg.fill_enable   <= 1'b0;
      cfg.fill_pattern  <= 64'd0;
      cfg.fill_code     <= 64'd0;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_DOUBLE_MODE:   cfg.double_mode   <= wr_data[0];
        REG_SIGN_MODE:     cfg.sign_mode     <= wr_data[1:0];
        REG_EXPONENT_BITS: cfg.exponent_bits <= wr_data[3:0];
        REG_MANTISSA_BITS: cfg.mantissa_bits <= wr_data[5:0];
        REG_MIN_EXPONENT:  cfg.min_exponent  <= wr_data[10:0];
        REG_FILL_ENABLE:   cfg.fill_enable   <= wr_data[0];
        REG_FILL_PATTERN:  cfg.fill_pattern  <= wr_data;
        REG_FILL_CODE:     cfg.fill_code     <= wr_data;
      endcase
    end
  end

  fsbe_split u_split (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (start && !busy),
    .value_bits (value_bits),
    .last_value (last_value),
    .s1         (s1)
  );

  fsbe_round u_round (
    .clk (clk),
    .rst (rst),
    .cfg (cfg),
    .s1  (s1),
    .s2  (s2)
  );

  fsbe_pack u_pack (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .s2        (s2),
    .done      (done),
    .code      (code),
    .is_fill   (is_fill),
    .last_code (last_code)
  );

  a_enter: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> s1.valid)
    else $error("accepted item did not enter the pipe");

  a_stage2: assert property (@(posedge clk) disable iff (rst)
    s2.valid |-> $past(s1.valid))
    else $error("stage 2 valid without stage 1 item");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, 3))
    else $error("result without an item accepted three cycles earlier");

endmodule
